>>> hdl/deq_pkg.sv
// Package: shared constants, codes and transaction types of the double-ended queue.
`default_nettype none

package deq_pkg;

  // Queue geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 8;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W    = 5;

  // Operation codes carried in the opcode field.
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  // Status codes returned with each result.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // Command transaction.
  typedef struct packed {
    logic [2:0]            opcode;
    logic [DATA_WIDTH-1:0] push_value;
  } deq_cmd_t;

  // Result transaction.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] pop_value;
    logic [1:0]            status;
    logic [COUNT_W-1:0]    element_count;
    logic                  is_empty;
  } deq_res_t;

endpackage

`default_nettype wire

>>> hdl/deq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/double_ended_queue.sv
// Bounded double-ended queue: the elements sit in a ring held in one synchronous RAM, with
// the front index, back index and occupancy in registers beside it. Each command transaction
// (push front, push back, pop front, pop back, clear) returns one result transaction with the
// popped value, a status, the element count and an empty flag. A command updates the
// indices and issues the RAM access in the cycle it is taken; it then waits in the pending
// stage, and the registered RAM read data is joined to it in the result register once that
// register is free.
// A new command is taken every cycle while results are drained; the sustained rate of one
// command per cycle is set by the single RAM read port and the in-place index update.
// A push into a full queue is dropped with overflow status; a pop from an empty queue
// returns zero with underflow status. After reset the queue is empty.
`default_nettype none

module double_ended_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire deq_pkg::deq_cmd_t cmd,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output deq_pkg::deq_res_t      res
);

  localparam logic [deq_pkg::IDX_W-1:0] LAST_IDX = deq_pkg::IDX_W'(deq_pkg::DEPTH - 1);
  localparam logic [deq_pkg::COUNT_W-1:0] FULL_CNT = deq_pkg::COUNT_W'(deq_pkg::DEPTH);

  // Ring indices and occupancy.
  logic [deq_pkg::IDX_W-1:0]   front_index, front_index_next;
  logic [deq_pkg::IDX_W-1:0]   back_index, back_index_next;
  logic [deq_pkg::COUNT_W-1:0] occupancy, occupancy_next;

  // Stage between the RAM read and the result register.
  logic                        pend_valid;
  logic                        pend_pop;
  logic [1:0]                  pend_status;
  logic [deq_pkg::COUNT_W-1:0] pend_count;

  // Per-command decode.
  logic [1:0]                     status_next;
  logic                           pop_next;
  logic                           ram_wr_en;
  logic [deq_pkg::IDX_W-1:0]      ram_wr_addr;
  logic                           ram_rd_en;
  logic [deq_pkg::IDX_W-1:0]      ram_rd_addr;
  logic [deq_pkg::DATA_WIDTH-1:0] ram_rd_data;

  logic accept;
  logic advance;
  logic is_full;
  logic is_void;
  logic [deq_pkg::IDX_W-1:0] front_prev, front_succ, back_prev, back_succ;

  assign advance   = pend_valid && (!res_valid || res_ready);
  assign cmd_ready = !pend_valid || advance;
  assign accept    = cmd_valid && cmd_ready;

  assign is_full = (occupancy == FULL_CNT);
  assign is_void = (occupancy == '0);

  // Ring neighbours of both indices.
  assign front_prev = (front_index == '0) ? LAST_IDX : front_index - 1'b1;
  assign front_succ = (front_index == LAST_IDX) ? '0 : front_index + 1'b1;
  assign back_prev  = (back_index == '0) ? LAST_IDX : back_index - 1'b1;
  assign back_succ  = (back_index == LAST_IDX) ? '0 : back_index + 1'b1;

  // Command decode: index update, RAM access and status.
  always_comb begin
    front_index_next = front_index;
    back_index_next  = back_index;
    occupancy_next   = occupancy;
    status_next      = deq_pkg::ST_OK;
    pop_next         = 1'b0;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = back_index;
    ram_rd_en        = 1'b0;
    ram_rd_addr      = front_index;
    unique case (cmd.opcode)
      deq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          status_next = deq_pkg::ST_OVERFLOW;
        end else begin
          front_index_next = front_prev;
          occupancy_next   = occupancy + 1'b1;
          ram_wr_en        = accept;
          ram_wr_addr      = front_prev;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          status_next = deq_pkg::ST_OVERFLOW;
        end else begin
          back_index_next = back_succ;
          occupancy_next  = occupancy + 1'b1;
          ram_wr_en       = accept;
          ram_wr_addr     = back_index;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (is_void) begin
          status_next = deq_pkg::ST_UNDERFLOW;
        end else begin
          front_index_next = front_succ;
          occupancy_next   = occupancy - 1'b1;
          pop_next         = 1'b1;
          ram_rd_en        = accept;
          ram_rd_addr      = front_index;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (is_void) begin
          status_next = deq_pkg::ST_UNDERFLOW;
        end else begin
          back_index_next = back_prev;
          occupancy_next  = occupancy - 1'b1;
          pop_next        = 1'b1;
          ram_rd_en       = accept;
          ram_rd_addr     = back_prev;
        end
      end
      deq_pkg::OP_CLEAR: begin
        front_index_next = '0;
        back_index_next  = '0;
        occupancy_next   = '0;
      end
      default: begin
      end
    endcase
  end

  // Element storage.
  deq_ram #(
    .WIDTH (deq_pkg::DATA_WIDTH),
    .DEPTH (deq_pkg::DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (cmd.push_value),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Index and occupancy registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      occupancy   <= '0;
    end else if (accept) begin
      front_index <= front_index_next;
      back_index  <= back_index_next;
      occupancy   <= occupancy_next;
    end
  end

  // Pending stage: holds a taken command, beside the registered RAM read data, until the result register takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (advance) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_pop    <= pop_next;
      pend_status <= status_next;
      pend_count  <= occupancy_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.pop_value     <= pend_pop ? ram_rd_data : '0;
      res.status        <= pend_status;
      res.element_count <= pend_count;
      res.is_empty      <= (pend_count == '0);
    end
  end

`ifndef SYNTH
  // The occupancy never exceeds the ring size.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= FULL_CNT)
    else $error("occupancy above ring size");

  // An empty or full ring has both indices on the same slot.
  a_idx_meet: assert property (@(posedge clk) disable iff (rst)
    (is_void || is_full) |-> (front_index == back_index))
    else $error("indices disagree with occupancy");

  // A push taken while full leaves the queue unchanged and reports overflow.
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (accept && is_full && (cmd.opcode == deq_pkg::OP_PUSH_FRONT ||
                           cmd.opcode == deq_pkg::OP_PUSH_BACK))
    |=> (pend_status == deq_pkg::ST_OVERFLOW) && $stable(occupancy))
    else $error("overflow push not dropped");

  // A stalled pending transaction holds its contents.
  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !advance) |=> pend_valid && $stable(pend_count) && $stable(pend_pop))
    else $error("pending transaction lost while stalled");

  // Nothing is written to the RAM without an accepted push.
  a_write_acc: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> accept && !is_full)
    else $error("RAM written outside an accepted push");
`endif

endmodule

`default_nettype wire
